>>> sv/crc64_stream_checker_macros.svh
// ----------------------------------------------------------------------------
// CRC-64 stream checker assertion macros
// Shared assertion forms for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef CRC64_STREAM_CHECKER_MACROS_SVH
`define CRC64_STREAM_CHECKER_MACROS_SVH

// Checked on every clock edge outside reset.
`define CRC64SC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CRC64SC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/crc64sc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-64 stream checker package
// Types, register indexes and reset values shared by the checker's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc64sc_pkg;

	localparam int CRC_W  = 64;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 2;

	localparam logic [CRC_W-1:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;
	localparam logic [CRC_W-1:0] INIT_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [CRC_W-1:0] FXOR_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

	// Register indexes; each register sits at byte address 8 * index.
	localparam logic [IDX_W-1:0] REG_POLY = 2'd0;
	localparam logic [IDX_W-1:0] REG_INIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_FXOR = 2'd2;

	localparam logic [ADDR_W-1:0] ADDR_POLY = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_INIT = 5'd8;
	localparam logic [ADDR_W-1:0] ADDR_FXOR = 5'd16;

	typedef struct packed {
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] initial_value;
		logic [CRC_W-1:0] final_xor;
	} cfg_t;

	typedef struct packed {
		logic              has_byte;
		logic [BYTE_W-1:0] payload_byte;
		logic              last_byte;
		logic [CRC_W-1:0]  expected_crc;
	} item_t;

endpackage

>>> sv/crc64sc_fold.sv
// ----------------------------------------------------------------------------
// CRC-64 byte fold
// Folds one byte into the running CRC with eight reflected shift steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64sc_fold (
	input  logic [crc64sc_pkg::CRC_W-1:0]  crc_in,
	input  logic [crc64sc_pkg::BYTE_W-1:0] data_byte,
	input  logic [crc64sc_pkg::CRC_W-1:0]  polynomial,
	output logic [crc64sc_pkg::CRC_W-1:0]  crc_out
);
	import crc64sc_pkg::*;

	always_comb begin
		logic [CRC_W-1:0] crc;
		logic             dropped;
		crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
		for (int k = 0; k < BYTE_W; k++) begin
			dropped = crc[0];
			crc     = crc >> 1;
			if (dropped) begin
				crc = crc ^ polynomial;
			end
		end
		crc_out = crc;
	end

endmodule

>>> sv/crc64sc_regs.sv
// ----------------------------------------------------------------------------
// CRC-64 configuration registers
// APB register file holding the polynomial, initial value and final XOR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64sc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crc64sc_pkg::ADDR_W-1:0]  paddr,
	input  logic [crc64sc_pkg::CRC_W-1:0]   pwdata,
	output logic [crc64sc_pkg::CRC_W-1:0]   prdata,
	output logic                            pready,
	output crc64sc_pkg::cfg_t               cfg
);
	import crc64sc_pkg::*;

	logic [IDX_W-1:0] reg_idx;
	logic             wr_en;
	cfg_t             cfg_q;

	// Registers are 8 bytes apart; the low address bits are ignored.
	assign reg_idx = paddr[ADDR_W-1:3];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial    <= POLY_RESET;
			cfg_q.initial_value <= INIT_RESET;
			cfg_q.final_xor     <= FXOR_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POLY: cfg_q.polynomial    <= pwdata;
				REG_INIT: cfg_q.initial_value <= pwdata;
				REG_FXOR: cfg_q.final_xor     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POLY: prdata = cfg_q.polynomial;
			REG_INIT: prdata = cfg_q.initial_value;
			REG_FXOR: prdata = cfg_q.final_xor;
			default:  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> sv/crc64_stream_checker.sv
// ----------------------------------------------------------------------------
// CRC-64 stream checker
// Running 64-bit CRC over a byte stream with a match flag per payload.
// ----------------------------------------------------------------------------
// The block takes one payload byte per request on the slave stream and folds
// it into a 64-bit running CRC (reflected shift, programmable polynomial; the
// reset polynomial is the ECMA-182 value used as is, and writing its reflected
// value gives the common XZ form). A request with tlast set closes the payload:
// one result request leaves on the master stream with the CRC after the final
// XOR in tdata and, in tuser, a flag telling whether it equals the expected
// CRC carried by the closing request. The running CRC is then reloaded from
// the initial value register. A request with tuser low carries no byte; with
// tlast low it changes nothing, with tlast high it closes the payload (an
// empty payload yields initial value XOR final XOR). The block sustains one
// request per clock cycle while no closing request waits in the input
// register. A request is registered at the input; from there the eight-step
// byte fold, the final XOR and the 64-bit compare run in one pass into the
// output register, from which the result is offered on the master side. The
// single running CRC register is the loop that sets this rate. While a result
// waits for the master side, the input register keeps taking requests and
// folding bytes that do not close a payload; a closing request holds in the
// input register, and stalls the slave side, until the waiting result leaves.
// Configuration must be written through the APB port only while the stream
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64_stream_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	// Slave tdata fields from bit 0 up: payload_byte[7:0], expected_crc[63:0].
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [71:0]                     s_axis_tdata,
	input  logic                            s_axis_tlast,
	// Slave tuser: bit 0 = has_byte.
	input  logic                            s_axis_tuser,
	// Master stream: tdata = crc_result[63:0].
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata,
	// Master tuser: bit 0 = crc_matches.
	output logic                            m_axis_tuser,
	// APB configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crc64sc_pkg::ADDR_W-1:0]  paddr,
	input  logic [crc64sc_pkg::CRC_W-1:0]   pwdata,
	output logic [crc64sc_pkg::CRC_W-1:0]   prdata,
	output logic                            pready
);
	import crc64sc_pkg::*;

	cfg_t             cfg;

	// Input register stage.
	logic             valid_s1;
	item_t            item_s1;

	// Running CRC state and the output register.
	logic [CRC_W-1:0] running_crc_q;
	logic             out_valid_q;
	logic [CRC_W-1:0] out_crc_q;
	logic             out_match_q;

	logic [CRC_W-1:0] folded_crc;
	logic [CRC_W-1:0] next_crc;
	logic [CRC_W-1:0] result_crc;
	logic             in_accept;
	logic             advance_s1;
	logic             load_out;

	crc64sc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc64sc_fold u_fold (
		.crc_in     (running_crc_q),
		.data_byte  (item_s1.payload_byte),
		.polynomial (cfg.polynomial),
		.crc_out    (folded_crc)
	);

	// A request that does not close a payload always moves on. A closing
	// request needs the output register free, or being emptied this cycle.
	assign advance_s1    = valid_s1 & (~item_s1.last_byte | ~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance_s1;
	assign in_accept     = s_axis_tvalid & s_axis_tready;
	assign load_out      = advance_s1 & item_s1.last_byte;

	// The byte field is ignored when the request carries no byte.
	assign next_crc   = item_s1.has_byte ? folded_crc : running_crc_q;
	assign result_crc = next_crc ^ cfg.final_xor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload of the input stage needs no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.has_byte     <= s_axis_tuser;
			item_s1.payload_byte <= s_axis_tdata[BYTE_W-1:0];
			item_s1.last_byte    <= s_axis_tlast;
			item_s1.expected_crc <= s_axis_tdata[BYTE_W+CRC_W-1:BYTE_W];
		end
	end

	// The running CRC reloads from the initial value when a payload closes,
	// so a new initial value written mid-payload waits for the next payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= INIT_RESET;
		end else if (advance_s1) begin
			running_crc_q <= item_s1.last_byte ? cfg.initial_value : next_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_crc_q   <= result_crc;
			out_match_q <= (result_crc == item_s1.expected_crc);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_crc_q;
	assign m_axis_tuser  = out_match_q;

endmodule

>>> sv/crc64sc_checker.sv
// ----------------------------------------------------------------------------
// CRC-64 stream checker port assertions
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc64_stream_checker_macros.svh"

module crc64sc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [63:0]                     m_axis_tdata,
	input logic                            m_axis_tuser,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [crc64sc_pkg::ADDR_W-1:0]  paddr,
	input logic [crc64sc_pkg::CRC_W-1:0]   pwdata,
	input logic [crc64sc_pkg::CRC_W-1:0]   prdata
);
	import crc64sc_pkg::*;

	// A waiting result must hold its value and flag.
	`CRC64SC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// With no result waiting nothing can block the input stage.
	`CRC64SC_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

	// A polynomial write is visible on a read in the following cycle.
	`CRC64SC_ASSERT(a_poly_readback, (psel && penable && pwrite && paddr == ADDR_POLY) ##1 (psel && penable && !pwrite && paddr == ADDR_POLY) |-> prdata == $past(pwdata), "polynomial readback mismatch")

	// No result is offered while reset is applied.
	`CRC64SC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind crc64_stream_checker crc64sc_checker u_crc64sc_checker (.*);
